// ===== src/assert_macros.svh =====
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/mpfb_pkg.sv =====
// Shared types and constants of the page-mode framebuffer blit unit.
package mpfb_pkg;

    // Default panel geometry.
    localparam int DEF_PANEL_COLS  = 128;
    localparam int DEF_PANEL_PAGES = 8;
    localparam int DEF_PANEL_ROWS  = 64;

    // Page index is at most three bits (up to eight pages).
    localparam int PAGE_W = 3;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    // Input action codes.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COL_SHIFT  = 2'd0;
    localparam logic [1:0] CFG_ROW_SHIFT  = 2'd1;
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd3;

    // Configuration reset values.
    localparam logic [7:0] RST_SRC_WIDTH  = 8'd128;
    localparam logic [7:0] RST_SRC_HEIGHT = 8'd64;

    // Panel command bytes of the readout.
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] pixel;
        logic       first;
    } t_q_item;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } t_back_ctl;

    typedef struct packed {
        logic [7:0] x_off;
        logic [6:0] y_off;
        logic [7:0] width;
        logic [7:0] height;
    } t_cfg;

endpackage

// ===== src/mpfb_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old data on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/mpfb_front.sv =====
// Front end: accepts items, classifies the action and queues them for the back end.
module mpfb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_pixel_byte,
    input  logic               i_first_byte,
    input  mpfb_pkg::t_back_ctl i_ctl,
    output logic               o_q_valid,
    output mpfb_pkg::t_q_item  o_q_item
);
    import mpfb_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_q_item          r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             full;
    logic             accept;
    logic             keep;
    logic             push;
    t_q_item          item;

    assign full   = (r_count == CNT_W'(Q_DEPTH));
    assign busy   = i_ctl.init_busy || full;
    assign accept = start && !busy;

    // Classify: drop the unused action code here.
    always_comb begin
        item.pixel = i_pixel_byte;
        item.first = i_first_byte;
        item.op    = OP_CLEAR;
        keep       = 1'b1;
        unique case (i_action)
            ACT_CLEAR: item.op = OP_CLEAR;
            ACT_PIXEL: item.op = OP_PIXEL;
            ACT_FLUSH: item.op = OP_FLUSH;
            default:   keep    = 1'b0;
        endcase
    end

    assign push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_ctl.pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (push && !i_ctl.pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!push && i_ctl.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= item;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rptr];
endmodule

// ===== src/mpfb_back.sv =====
// Back end: clears the store, places pixels by read-modify-write and steps the readout.
module mpfb_back #(
    parameter int PANEL_COLS  = mpfb_pkg::DEF_PANEL_COLS,
    parameter int PANEL_PAGES = mpfb_pkg::DEF_PANEL_PAGES,
    parameter int PANEL_ROWS  = mpfb_pkg::DEF_PANEL_ROWS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpfb_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  mpfb_pkg::t_q_item   i_q_item,
    output mpfb_pkg::t_back_ctl o_ctl,
    output logic                o_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_is_data,
    output logic                o_frame_last
);
    import mpfb_pkg::*;

    localparam int DEPTH = PANEL_COLS * PANEL_PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(PANEL_COLS + 3);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_PIX   = 5'b00100,
        S_FRD   = 5'b01000,
        S_FOUT  = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_init;
    logic [AW-1:0]     r_clr_addr;
    logic [2:0]        r_k;
    logic [7:0]        r_pixel;
    logic [7:0]        r_src_col;
    logic [7:0]        r_src_row;
    logic [PAGE_W-1:0] r_flush_page;
    logic [PW-1:0]     r_flush_pos;

    // Write stage of the pixel pipeline.
    logic              r_b_valid;
    logic [AW-1:0]     r_b_addr;
    logic [2:0]        r_b_bit;
    logic              r_b_pix;
    // Last pixel write, forwarded over the read gap.
    logic              r_fw_valid;
    logic [AW-1:0]     r_fw_addr;
    logic [7:0]        r_fw_data;

    logic              r_o_valid;
    logic [7:0]        r_o_byte;
    logic              r_o_data;
    logic              r_o_last;

    logic              pop;
    logic signed [9:0] px;
    logic signed [9:0] py;
    logic              in_rng;
    logic              row_ok;
    logic              wrap;
    logic [AW-1:0]     pix_idx;
    logic [AW-1:0]     flush_idx;
    logic [7:0]        base;
    logic [7:0]        merged;
    logic [7:0]        rdata;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [7:0]        wdata;
    logic [AW-1:0]     raddr;
    logic              flush_end;
    logic              frame_end;
    logic [7:0]        flush_byte;

    assign pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_ctl = '{pop: pop, init_busy: r_init};

    // Panel position of the current source pixel.
    assign px = $signed({2'b00, r_src_col}) + $signed({{2{i_cfg.x_off[7]}}, i_cfg.x_off});
    assign py = $signed({2'b00, r_src_row}) + $signed({{3{i_cfg.y_off[6]}}, i_cfg.y_off});
    assign in_rng = !px[9] && (px < $signed(10'(PANEL_COLS)))
                 && !py[9] && (py < $signed(10'(PANEL_ROWS)))
                 && (py < $signed(10'(PANEL_PAGES * 8)));
    assign row_ok  = (r_src_row < i_cfg.height);
    assign wrap    = ({1'b0, r_src_col} + 9'd1) >= {1'b0, i_cfg.width};
    assign pix_idx = AW'(py[5:3]) * AW'(PANEL_COLS) + AW'(px[8:0]);

    assign flush_idx = AW'(r_flush_page) * AW'(PANEL_COLS) + AW'(r_flush_pos - PW'(3));
    assign flush_end = (r_flush_pos == PW'(PANEL_COLS + 2));
    assign frame_end = flush_end && (r_flush_page == PAGE_W'(PANEL_PAGES - 1));

    // Merge the pixel into the byte, taking the forwarded copy on an address match.
    assign base   = (r_fw_valid && (r_fw_addr == r_b_addr)) ? r_fw_data : rdata;
    assign merged = r_b_pix ? (base | (8'd1 << r_b_bit)) : (base & ~(8'd1 << r_b_bit));

    assign we    = (r_state == S_CLEAR) || r_b_valid;
    assign waddr = (r_state == S_CLEAR) ? r_clr_addr : r_b_addr;
    assign wdata = (r_state == S_CLEAR) ? 8'd0 : merged;
    assign raddr = (r_state == S_FRD) ? flush_idx : pix_idx;

    mpfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (r_flush_pos == PW'(0)) begin
            flush_byte = CMD_PAGE_BASE | {{(8 - PAGE_W){1'b0}}, r_flush_page};
        end else if (r_flush_pos == PW'(1)) begin
            flush_byte = CMD_COL_LO;
        end else if (r_flush_pos == PW'(2)) begin
            flush_byte = CMD_COL_HI;
        end else begin
            flush_byte = rdata;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_q_item.op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_PIXEL: n_state = S_PIX;
                        OP_FLUSH: n_state = S_FRD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_PIX:   if (r_k == 3'd7) n_state = S_IDLE;
            S_FRD:   n_state = S_FOUT;
            S_FOUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_init       <= 1'b1;
            r_clr_addr   <= '0;
            r_k          <= '0;
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_flush_page <= '0;
            r_flush_pos  <= '0;
            r_b_valid    <= 1'b0;
            r_fw_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_b_valid  <= (r_state == S_PIX) && row_ok && in_rng;
            r_fw_valid <= r_b_valid;
            r_o_valid  <= (r_state == S_FOUT);

            if (r_state == S_CLEAR) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_addr <= '0;
                    r_init     <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end

            if (pop && (i_q_item.op == OP_PIXEL)) begin
                r_k <= '0;
                if (i_q_item.first) begin
                    r_src_col <= '0;
                    r_src_row <= '0;
                end
            end

            if (r_state == S_PIX) begin
                r_k <= r_k + 3'd1;
                if (row_ok) begin
                    if (wrap) begin
                        r_src_col <= '0;
                        r_src_row <= r_src_row + 8'd1;
                    end else begin
                        r_src_col <= r_src_col + 8'd1;
                    end
                end
            end

            if (r_state == S_FOUT) begin
                if (flush_end) begin
                    r_flush_pos  <= '0;
                    r_flush_page <= (r_flush_page == PAGE_W'(PANEL_PAGES - 1))
                                  ? '0 : r_flush_page + PAGE_W'(1);
                end else begin
                    r_flush_pos <= r_flush_pos + PW'(1);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_pixel <= i_q_item.pixel;
        end
        if (r_state == S_PIX) begin
            r_b_addr <= pix_idx;
            r_b_bit  <= py[2:0];
            r_b_pix  <= r_pixel[r_k];
        end
        r_fw_addr <= r_b_addr;
        r_fw_data <= merged;
        if (r_state == S_FOUT) begin
            r_o_byte <= flush_byte;
            r_o_data <= (r_flush_pos >= PW'(3));
            r_o_last <= frame_end;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_is_data    = r_o_data;
    assign o_frame_last = r_o_last;
endmodule

// ===== src/mono_page_framebuffer_blit_unit.sv =====
// Top level of the page-mode monochrome framebuffer blit unit.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-----------------------------------
//  item    | in        | start & !busy             | i_action, i_pixel_byte, i_first_byte
//  config  | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//  result  | out       | o_valid strobe, one cycle | o_out_byte, o_is_data, o_frame_last
//
// In the back end a pixel byte is taken from the queue, then each of its eight pixels
// gets a framebuffer read, with the write in the cycle after it (a one-deep forward
// covers the read gap). A clear is taken from the queue, then writes every store byte,
// one store write per cycle. A flush step is taken, then passes S_FRD and S_FOUT; its
// result strobes the cycle after S_FOUT. After reset the store is swept to zero with
// busy high; config writes are taken at all times. The two-item queue lets the front
// take items while the back works; busy rises when it is full. The receiver cannot stall.

`include "assert_macros.svh"

module mono_page_framebuffer_blit_unit #(
    parameter int PANEL_COLS  = mpfb_pkg::DEF_PANEL_COLS,
    parameter int PANEL_PAGES = mpfb_pkg::DEF_PANEL_PAGES,
    parameter int PANEL_ROWS  = mpfb_pkg::DEF_PANEL_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_pixel_byte,
    input  logic       i_first_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_frame_last
);
    import mpfb_pkg::*;

    t_cfg      r_cfg;
    t_back_ctl ctl;
    t_q_item   q_item;
    logic      q_valid;
    logic      cmd_ok;

    // Register writes are always taken; the back end reads them only while working.
    // Users must change them only while the block is idle; it is not enforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_off  <= '0;
            r_cfg.y_off  <= '0;
            r_cfg.width  <= RST_SRC_WIDTH;
            r_cfg.height <= RST_SRC_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COL_SHIFT:  r_cfg.x_off  <= i_cfg_data;
                CFG_ROW_SHIFT:  r_cfg.y_off  <= i_cfg_data[6:0];
                CFG_SRC_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_cfg.height <= i_cfg_data;
                default:        r_cfg.x_off  <= r_cfg.x_off;
            endcase
        end
    end

    // Front end: take and classify items, hold them in the queue.
    mpfb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_pixel_byte (i_pixel_byte),
        .i_first_byte (i_first_byte),
        .i_ctl        (ctl),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item)
    );

    // Back end: carry out clears, pixel placement and the readout.
    mpfb_back #(
        .PANEL_COLS  (PANEL_COLS),
        .PANEL_PAGES (PANEL_PAGES),
        .PANEL_ROWS  (PANEL_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_ctl        (ctl),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_frame_last (o_frame_last)
    );

    // Command bytes are a page select or one of the two column commands.
    assign cmd_ok = (o_out_byte[7:4] == CMD_PAGE_BASE[7:4]) || (o_out_byte == CMD_COL_LO)
                 || (o_out_byte == CMD_COL_HI);

    // The frame-end mark only rides on a data byte.
    `ASSERT_IMPL(a_last_is_data, i_clk, i_rst_n, o_valid && o_frame_last, o_is_data)
    // A flush step passes S_FRD and S_FOUT, so results never strobe back to back.
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    // Only known command codes leave as command bytes.
    `ASSERT_IMPL(a_cmd_code, i_clk, i_rst_n, o_valid && !o_is_data, cmd_ok)
    // Nothing is taken while the reset sweep runs.
    `ASSERT_IMPL(a_busy_in_sweep, i_clk, i_rst_n, ctl.init_busy, busy && !ctl.pop)
endmodule

// ===== sim/mpfb_readout_checker.sv =====
// Checker for the blit unit: tracks the framebuffer, predicts readout bytes, compares.
`timescale 1ns / 1ps

module mpfb_readout_checker #(
    parameter int PANEL_COLS  = mpfb_pkg::DEF_PANEL_COLS,
    parameter int PANEL_PAGES = mpfb_pkg::DEF_PANEL_PAGES,
    parameter int PANEL_ROWS  = mpfb_pkg::DEF_PANEL_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_pixel_byte,
    input  logic       i_first_byte,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  logic [7:0] i_out_byte,
    input  logic       i_is_data,
    input  logic       i_frame_last,
    output int         o_fail_count,
    output int         o_pending
);
    import mpfb_pkg::*;

    localparam int STORE_BYTES = PANEL_COLS * PANEL_PAGES;
    localparam int PAGE_STEPS  = PANEL_COLS + 3;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       last;
    } t_panel_byte;

    logic [7:0]  frame_mem [STORE_BYTES];
    logic [7:0]  col_pos;
    logic [7:0]  row_pos;
    int          read_page;
    int          read_step;
    t_cfg        cfg;
    t_panel_byte panel_q [$];
    int          errors = 0;

    function automatic void wipe_frame();
        for (int i = 0; i < STORE_BYTES; i++) begin
            frame_mem[i] = '0;
        end
    endfunction

    // One source pixel: place it unless clipped, then advance the source position.
    function automatic void plot_pixel(logic pix);
        int px;
        int py;
        if (row_pos >= cfg.height) return;
        px = int'(col_pos) + int'($signed(cfg.x_off));
        py = int'(row_pos) + int'($signed(cfg.y_off));
        if (px >= 0 && px < PANEL_COLS && py >= 0 && py < PANEL_ROWS &&
            py < PANEL_PAGES * 8) begin
            frame_mem[(py / 8) * PANEL_COLS + px][py % 8] = pix;
        end
        // A width of zero ends the row on every pixel.
        if (int'(col_pos) + 1 >= int'(cfg.width)) begin
            col_pos = '0;
            row_pos = row_pos + 8'd1;
        end else begin
            col_pos = col_pos + 8'd1;
        end
    endfunction

    function automatic void blit_byte(logic [7:0] pixels, logic restart);
        if (restart) begin
            col_pos = '0;
            row_pos = '0;
        end
        for (int i = 0; i < 8; i++) begin
            plot_pixel(pixels[i]);
        end
    endfunction

    function automatic t_panel_byte next_panel_byte();
        t_panel_byte b;
        int col;
        b = '0;
        if (read_page >= PANEL_PAGES) read_page = 0;
        if (read_step == 0) begin
            b.value = CMD_PAGE_BASE | 8'(read_page & 7);
        end else if (read_step == 1) begin
            b.value = CMD_COL_LO;
        end else if (read_step == 2) begin
            b.value = CMD_COL_HI;
        end else begin
            col       = read_step - 3;
            b.value   = frame_mem[read_page * PANEL_COLS + col];
            b.is_data = 1'b1;
            b.last    = (col + 1 >= PANEL_COLS) && (read_page + 1 >= PANEL_PAGES);
        end
        // Next page after a page's last byte; page 0 after the frame's last byte.
        if (read_step + 1 >= PAGE_STEPS) begin
            read_step = 0;
            read_page = (read_page + 1 >= PANEL_PAGES) ? 0 : read_page + 1;
        end else begin
            read_step = read_step + 1;
        end
        return b;
    endfunction

    always @(posedge i_clk) begin
        t_panel_byte want;
        t_panel_byte got;
        if (!i_rst_n) begin
            wipe_frame();
            col_pos   = '0;
            row_pos   = '0;
            read_page = 0;
            read_step = 0;
            cfg       = '{x_off: '0, y_off: '0, width: RST_SRC_WIDTH, height: RST_SRC_HEIGHT};
            panel_q.delete();
        end else begin
            // Compare first: a byte out now belongs to an item taken earlier.
            if (i_valid) begin
                got = '{value: i_out_byte, is_data: i_is_data, last: i_frame_last};
                if (panel_q.size() == 0) begin
                    if (errors < MAX_SHOWN)
                        $display("%0t: unexpected readout byte %h data %b last %b",
                                 $realtime, got.value, got.is_data, got.last);
                    errors++;
                end else begin
                    want = panel_q.pop_front();
                    if (got !== want) begin
                        if (errors < MAX_SHOWN)
                            $display("%0t: readout mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     $realtime, want.value, want.is_data, want.last,
                                     got.value, got.is_data, got.last);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COL_SHIFT:  cfg.x_off  = i_cfg_data;
                    CFG_ROW_SHIFT:  cfg.y_off  = i_cfg_data[6:0];
                    CFG_SRC_WIDTH:  cfg.width  = i_cfg_data;
                    CFG_SRC_HEIGHT: cfg.height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                case (i_action)
                    ACT_CLEAR: wipe_frame();
                    ACT_PIXEL: blit_byte(i_pixel_byte, i_first_byte);
                    ACT_FLUSH: panel_q.push_back(next_panel_byte());
                    default: ;
                endcase
            end
        end
        o_fail_count = errors;
        o_pending    = panel_q.size();
    end

endmodule

// ===== sim/tb_mono_page_framebuffer_blit_unit.sv =====
// Testbench top for the framebuffer blit unit: drives items and config, gives the verdict.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_blit_unit;

    import mpfb_pkg::*;

    localparam int PERIOD          = 12;
    localparam int STORE_BYTES     = DEF_PANEL_COLS * DEF_PANEL_PAGES;
    // A clear holds the back end for a whole store sweep; let one finish at least.
    localparam int QUIET_CYCLES    = STORE_BYTES + 64;
    // At the end, room for an in-flight clear plus two queued ones.
    localparam int DRAIN_CYCLES    = 3 * (STORE_BYTES + 1) + 64;
    localparam int LIMIT_CYCLES    = 4000000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 85;
    // Action code the block has no use for.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       start        = 1'b0;
    logic [1:0] i_action     = ACT_CLEAR;
    logic [7:0] i_pixel_byte = '0;
    logic       i_first_byte = 1'b0;
    logic       i_cfg_valid  = 1'b0;
    logic [1:0] i_cfg_index  = CFG_COL_SHIFT;
    logic [7:0] i_cfg_data   = '0;
    logic       busy;
    logic       o_cfg_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_data;
    logic       o_frame_last;
    int         fail_count;
    int         pending;
    bit         gaps_on;

    always #(PERIOD / 2) i_clk = ~i_clk;

    mono_page_framebuffer_blit_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_pixel_byte (i_pixel_byte),
        .i_first_byte (i_first_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_frame_last (o_frame_last)
    );

    // The checker sees the same pins; it owns prediction and comparison.
    mpfb_readout_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_action     (i_action),
        .i_pixel_byte (i_pixel_byte),
        .i_first_byte (i_first_byte),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (o_valid),
        .i_out_byte   (o_out_byte),
        .i_is_data    (o_is_data),
        .i_frame_last (o_frame_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Present one item and hold it until the block takes it. Start stays high on return if
    // no gap dropped it, so a following item goes back to back; lower it only for a gap.
    task automatic send_item(logic [1:0] act, logic [7:0] pixels, logic restart);
        i_action     <= act;
        i_pixel_byte <= pixels;
        i_first_byte <= restart;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        // Drop start for a short random burst now and then.
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Write one register; valid is left high for the next write.
    task automatic put_reg(logic [1:0] index, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_config(logic [7:0] x, logic [7:0] y, logic [7:0] w, logic [7:0] h);
        put_reg(CFG_COL_SHIFT, x);
        put_reg(CFG_ROW_SHIFT, y);
        put_reg(CFG_SRC_WIDTH, w);
        put_reg(CFG_SRC_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // Close a phase: a trailing flush step comes out only after everything queued
    // ahead of it is done, so once nothing is owed the block is idle.
    task automatic settle();
        send_item(ACT_FLUSH, 8'($urandom), 1'($urandom));
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Mostly pixel bytes in runs that restart the source now and then, mixed
    // with readout steps; a few clears and unused codes as noise.
    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send_item(ACT_PIXEL, 8'($urandom), $urandom_range(0, 15) == 0);
        else if (pick < 88)
            send_item(ACT_FLUSH, 8'($urandom), 1'($urandom));
        else if (pick < 91)
            send_item(ACT_CLEAR, 8'($urandom), 1'($urandom));
        else if (pick < 95)
            send_item(ACT_UNUSED, 8'($urandom), 1'($urandom));
        else
            send_item(ACT_PIXEL, 8'($urandom), 1'b1);
    endtask

    initial begin
        gaps_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry, written explicitly. Commands, then data from an empty store.
        write_config(8'h00, 8'h00, RST_SRC_WIDTH, RST_SRC_HEIGHT);
        repeat (4) send_item(ACT_FLUSH, 8'h00, 1'b0);
        send_item(ACT_PIXEL, 8'hFF, 1'b1);
        send_item(ACT_PIXEL, 8'h5A, 1'b0);
        // Unused code must change nothing, first byte included.
        send_item(ACT_UNUSED, 8'hFF, 1'b1);
        send_item(ACT_PIXEL, 8'h81, 1'b1);
        repeat (3) send_item(ACT_FLUSH, 8'hFF, 1'b1);
        // Clear keeps the readout position; the next data byte must be zero.
        send_item(ACT_CLEAR, 8'hFF, 1'b1);
        send_item(ACT_FLUSH, 8'h00, 1'b0);
        settle();

        // Most negative offsets, widest source: everything clips. The y data has
        // bit 7 set, which the 7-bit register drops.
        write_config(8'h80, 8'hC0, 8'hFF, 8'hFF);
        send_item(ACT_PIXEL, 8'hFF, 1'b1);
        send_item(ACT_PIXEL, 8'h3C, 1'b0);
        settle();

        // Most positive offsets on a one-pixel source: only the bottom-right
        // corner lands, later pixels fall past the source height.
        write_config(8'h7F, 8'h3F, 8'h01, 8'h01);
        send_item(ACT_PIXEL, 8'hFF, 1'b1);
        send_item(ACT_PIXEL, 8'h00, 1'b0);
        settle();

        // Zero width acts as width one; one row up clips the first pixel.
        write_config(8'h02, 8'h7F, 8'h00, 8'h03);
        send_item(ACT_PIXEL, 8'hA5, 1'b1);
        settle();

        // Zero height: every pixel is ignored.
        write_config(8'h00, 8'h00, 8'h08, 8'h00);
        send_item(ACT_PIXEL, 8'hFF, 1'b1);
        settle();

        // Random phases; the last two run with no gaps at all.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            gaps_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
                write_config(8'($urandom_range(0, 64) - 32), 8'($urandom_range(0, 40) - 20),
                             8'($urandom_range(1, 48)), 8'($urandom_range(1, 48)));
            repeat (ITEMS_PER_PHASE) random_item();
            settle();
        end

        // Hold off long enough for any stray byte to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("mono_page_framebuffer_blit_unit verification clean");
        end else begin
            $display("mono_page_framebuffer_blit_unit verification failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing byte ends here.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("mono_page_framebuffer_blit_unit verification failed");
        $finish;
    end

endmodule
